>>> hdl/sps_pkg.sv
package sps_pkg;

  localparam int ANGLE_W = 13;
  localparam int RPM_W   = 16;
  localparam int GAIN_W  = 16;
  localparam int SPEED_W = 11;
  localparam int LIMIT_W = 15;
  localparam int TGT_W   = SPEED_W + 1;
  localparam int ERR_W   = 17;
  localparam int DIFF_W  = ERR_W + 1;
  localparam int P_W     = ERR_W + GAIN_W;
  localparam int D_W     = DIFF_W + GAIN_W;
  localparam int DRIVE_W = 16;
  localparam int IDX_W   = 3;
  localparam int DATA_W  = 16;

  localparam int ENC_COUNTS = 8192;

  localparam logic [IDX_W-1:0] REG_PROP_GAIN   = 3'd0;
  localparam logic [IDX_W-1:0] REG_INTEG_GAIN  = 3'd1;
  localparam logic [IDX_W-1:0] REG_DERIV_GAIN  = 3'd2;
  localparam logic [IDX_W-1:0] REG_SWEEP_SPEED = 3'd3;
  localparam logic [IDX_W-1:0] REG_UPPER_LIMIT = 3'd4;
  localparam logic [IDX_W-1:0] REG_LOWER_LIMIT = 3'd5;
  localparam logic [IDX_W-1:0] REG_INTEG_LIMIT = 3'd6;
  localparam logic [IDX_W-1:0] REG_DRIVE_LIMIT = 3'd7;

  typedef struct packed {
    logic signed [GAIN_W-1:0]  prop_gain;
    logic signed [GAIN_W-1:0]  integ_gain;
    logic signed [GAIN_W-1:0]  deriv_gain;
    logic signed [SPEED_W-1:0] sweep_speed;
    logic [ANGLE_W-1:0]        upper_limit;
    logic [ANGLE_W-1:0]        lower_limit;
    logic [LIMIT_W-1:0]        integ_limit;
    logic [LIMIT_W-1:0]        drive_limit;
  } cfg_t;

  typedef struct packed {
    logic signed [ERR_W-1:0]  err;
    logic signed [DIFF_W-1:0] diff;
    logic                     spin_pos;
    logic                     send;
  } err_stage_t;

  typedef struct packed {
    logic signed [P_W-1:0] p;
    logic signed [P_W-1:0] i;
    logic signed [D_W-1:0] d;
    logic                  spin_pos;
    logic                  send;
  } prod_stage_t;

endpackage

>>> hdl/sweeping_speed_pid_core.sv
// Sweeping speed PID controller. Each transfer on the input channel is one control tick with
// the rotor angle and measured speed; each tick gives exactly one result with the new clamped
// drive voltage, the sign of the current target, the frame flag (every SEND_EVERY-th tick,
// starting with the first) and the voltage of the previous tick for that frame. The datapath
// is a five-register pipeline (input, error, gain products, integral, output), and one tick
// is taken every cycle while the output is not stalled; the integral accumulator does its add
// and clamp combinationally ahead of its register. Configuration writes are always accepted
// and must only be issued while no tick is in flight.
module sweeping_speed_pid_core #(
  parameter int GAIN_FRAC_BITS = 8,
  parameter int SEND_EVERY     = 10
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [sps_pkg::IDX_W-1:0]          cfg_index,
  input  logic [sps_pkg::DATA_W-1:0]         cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [sps_pkg::ANGLE_W-1:0]        encoder_angle,
  input  logic signed [sps_pkg::RPM_W-1:0]   measured_rpm,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [sps_pkg::DRIVE_W-1:0] drive_voltage,
  output logic                               spin_positive,
  output logic                               send_now,
  output logic signed [sps_pkg::DRIVE_W-1:0] sent_voltage
);
  import sps_pkg::*;

  cfg_t        cfg;
  logic        s1_valid;
  logic        s1_ready;
  err_stage_t  s1;
  logic        s2_valid;
  logic        s2_ready;
  prod_stage_t s2;

  sps_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  sps_error #(
    .SEND_EVERY (SEND_EVERY)
  ) u_error (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .encoder_angle (encoder_angle),
    .measured_rpm  (measured_rpm),
    .s1_valid      (s1_valid),
    .s1_ready      (s1_ready),
    .s1            (s1)
  );

  sps_mult u_mult (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .s1_valid (s1_valid),
    .s1_ready (s1_ready),
    .s1       (s1),
    .s2_valid (s2_valid),
    .s2_ready (s2_ready),
    .s2       (s2)
  );

  sps_accum #(
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_accum (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .s2_valid      (s2_valid),
    .s2_ready      (s2_ready),
    .s2            (s2),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .drive_voltage (drive_voltage),
    .spin_positive (spin_positive),
    .send_now      (send_now),
    .sent_voltage  (sent_voltage)
  );

endmodule

>>> hdl/sps_regs.sv
module sps_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [sps_pkg::IDX_W-1:0]  cfg_index,
  input  logic [sps_pkg::DATA_W-1:0] cfg_data,
  output sps_pkg::cfg_t              cfg
);
  import sps_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prop_gain   <= 16'sd2560;
      cfg.integ_gain  <= 16'sd512;
      cfg.deriv_gain  <= 16'sd0;
      cfg.sweep_speed <= 11'sd1;
      cfg.upper_limit <= 13'd6075;
      cfg.lower_limit <= 13'd2117;
      cfg.integ_limit <= 15'd30000;
      cfg.drive_limit <= 15'd30000;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PROP_GAIN:   cfg.prop_gain   <= GAIN_W'(cfg_data);
        REG_INTEG_GAIN:  cfg.integ_gain  <= GAIN_W'(cfg_data);
        REG_DERIV_GAIN:  cfg.deriv_gain  <= GAIN_W'(cfg_data);
        REG_SWEEP_SPEED: cfg.sweep_speed <= cfg_data[SPEED_W-1:0];
        REG_UPPER_LIMIT: cfg.upper_limit <= cfg_data[ANGLE_W-1:0];
        REG_LOWER_LIMIT: cfg.lower_limit <= cfg_data[ANGLE_W-1:0];
        REG_INTEG_LIMIT: cfg.integ_limit <= cfg_data[LIMIT_W-1:0];
        REG_DRIVE_LIMIT: cfg.drive_limit <= cfg_data[LIMIT_W-1:0];
      endcase
    end
  end

endmodule

>>> hdl/sps_error.sv
module sps_error #(
  parameter int SEND_EVERY = 10
) (
  input  logic                             clk,
  input  logic                             rst,
  input  sps_pkg::cfg_t                    cfg,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [sps_pkg::ANGLE_W-1:0]      encoder_angle,
  input  logic signed [sps_pkg::RPM_W-1:0] measured_rpm,
  output logic                             s1_valid,
  input  logic                             s1_ready,
  output sps_pkg::err_stage_t              s1
);
  import sps_pkg::*;

  localparam int CNT_W = (SEND_EVERY > 1) ? $clog2(SEND_EVERY) : 1;

  logic                     v0;
  logic [ANGLE_W-1:0]       angle_q;
  logic signed [RPM_W-1:0]  meas_q;
  logic                     reversed;
  logic                     reversed_next;
  logic signed [ERR_W-1:0]  prev_error;
  logic [CNT_W-1:0]         tick_count;
  logic [ANGLE_W-1:0]       angle_red;
  logic signed [TGT_W-1:0]  speed_x;
  logic signed [TGT_W-1:0]  target;
  logic signed [ERR_W-1:0]  err;
  logic                     s1_free;
  logic                     adv;
  logic                     accept;

  assign s1_free  = !s1_valid || s1_ready;
  assign adv      = v0 && s1_free;
  assign in_stall = v0 && !s1_free;
  assign accept   = in_valid && !in_stall;

  assign angle_red = ANGLE_W'(32'(angle_q) % ENC_COUNTS);
  assign speed_x   = TGT_W'(cfg.sweep_speed);

  always_comb begin
    reversed_next = reversed;
    priority if (angle_red < cfg.lower_limit) begin
      reversed_next = 1'b0;
    end else if (angle_red > cfg.upper_limit) begin
      reversed_next = 1'b1;
    end
  end

  assign target = reversed_next ? -speed_x : speed_x;
  assign err    = ERR_W'(target) - ERR_W'(meas_q);

  always_ff @(posedge clk) begin
    if (rst) begin
      v0         <= 1'b0;
      s1_valid   <= 1'b0;
      reversed   <= 1'b0;
      prev_error <= '0;
      tick_count <= '0;
    end else begin
      if (accept) begin
        v0 <= 1'b1;
      end else if (adv) begin
        v0 <= 1'b0;
      end
      if (adv) begin
        s1_valid   <= 1'b1;
        reversed   <= reversed_next;
        prev_error <= err;
        if (tick_count == CNT_W'(SEND_EVERY - 1)) begin
          tick_count <= '0;
        end else begin
          tick_count <= tick_count + CNT_W'(1);
        end
      end else if (s1_ready) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      angle_q <= encoder_angle;
      meas_q  <= measured_rpm;
    end
    if (adv) begin
      s1.err      <= err;
      s1.diff     <= DIFF_W'(err) - DIFF_W'(prev_error);
      s1.spin_pos <= (target > TGT_W'(0));
      s1.send     <= (tick_count == '0);
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    tick_count <= CNT_W'(SEND_EVERY - 1))
    else $error("Tick counter left its range.");

  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> v0 && s1_valid && !s1_ready)
    else $error("Input stalled with room in the error stage.");

  assert property (@(posedge clk) disable iff (rst)
    adv |=> prev_error == $past(err))
    else $error("Previous error not taken on a stage transfer.");

endmodule

>>> hdl/sps_mult.sv
module sps_mult (
  input  logic                 clk,
  input  logic                 rst,
  input  sps_pkg::cfg_t        cfg,
  input  logic                 s1_valid,
  output logic                 s1_ready,
  input  sps_pkg::err_stage_t  s1,
  output logic                 s2_valid,
  input  logic                 s2_ready,
  output sps_pkg::prod_stage_t s2
);
  import sps_pkg::*;

  logic adv;

  assign s1_ready = !s2_valid || s2_ready;
  assign adv      = s1_valid && s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= 1'b1;
    end else if (s2_ready) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2.p        <= P_W'(s1.err) * P_W'(cfg.prop_gain);
      s2.i        <= P_W'(s1.err) * P_W'(cfg.integ_gain);
      s2.d        <= D_W'(s1.diff) * D_W'(cfg.deriv_gain);
      s2.spin_pos <= s1.spin_pos;
      s2.send     <= s1.send;
    end
  end

endmodule

>>> hdl/sps_accum.sv
module sps_accum #(
  parameter int GAIN_FRAC_BITS = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  sps_pkg::cfg_t                      cfg,
  input  logic                               s2_valid,
  output logic                               s2_ready,
  input  sps_pkg::prod_stage_t               s2,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [sps_pkg::DRIVE_W-1:0] drive_voltage,
  output logic                               spin_positive,
  output logic                               send_now,
  output logic signed [sps_pkg::DRIVE_W-1:0] sent_voltage
);
  import sps_pkg::*;

  localparam int IACC_W = LIMIT_W + GAIN_FRAC_BITS + 1;
  localparam int ISUM_W = ((IACC_W > P_W) ? IACC_W : P_W) + 1;
  localparam int PD_W   = D_W + 1;
  localparam int SUM_W  = ((PD_W > IACC_W) ? PD_W : IACC_W) + 1;
  localparam logic [SUM_W-1:0] BIAS = SUM_W'((64'd1 << GAIN_FRAC_BITS) - 64'd1);

  logic                      v3;
  logic signed [PD_W-1:0]    pd_q;
  logic                      spin_q;
  logic                      send_q;
  logic signed [IACC_W-1:0]  integ_acc;
  logic signed [IACC_W-1:0]  integ_next;
  logic signed [DRIVE_W-1:0] last_drive;
  logic signed [ISUM_W-1:0]  ilim;
  logic signed [ISUM_W-1:0]  isum;
  logic signed [SUM_W-1:0]   dlim;
  logic signed [SUM_W-1:0]   sum;
  logic signed [SUM_W-1:0]   csum;
  logic signed [SUM_W-1:0]   rounded;
  logic signed [DRIVE_W-1:0] drive;
  logic                      out_free;
  logic                      adv23;
  logic                      adv3o;

  assign out_free = !out_valid || !out_stall;
  assign s2_ready = !v3 || out_free;
  assign adv23    = s2_valid && s2_ready;
  assign adv3o    = v3 && out_free;

  assign ilim = ISUM_W'(cfg.integ_limit) <<< GAIN_FRAC_BITS;
  assign isum = ISUM_W'(integ_acc) + ISUM_W'(s2.i);

  always_comb begin
    if (isum > ilim) begin
      integ_next = IACC_W'(ilim);
    end else if (isum < -ilim) begin
      integ_next = IACC_W'(-ilim);
    end else begin
      integ_next = IACC_W'(isum);
    end
  end

  assign dlim = SUM_W'(cfg.drive_limit) <<< GAIN_FRAC_BITS;
  assign sum  = SUM_W'(pd_q) + SUM_W'(integ_acc);

  always_comb begin
    if (sum > dlim) begin
      csum = dlim;
    end else if (sum < -dlim) begin
      csum = -dlim;
    end else begin
      csum = sum;
    end
  end

  // Negative values are biased before the shift so the division truncates toward zero.
  assign rounded = csum + (csum[SUM_W-1] ? BIAS : '0);
  assign drive   = DRIVE_W'(rounded >>> GAIN_FRAC_BITS);

  always_ff @(posedge clk) begin
    if (rst) begin
      v3         <= 1'b0;
      out_valid  <= 1'b0;
      integ_acc  <= '0;
      last_drive <= '0;
    end else begin
      if (adv23) begin
        v3        <= 1'b1;
        integ_acc <= integ_next;
      end else if (adv3o) begin
        v3 <= 1'b0;
      end
      if (adv3o) begin
        out_valid  <= 1'b1;
        last_drive <= drive;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv23) begin
      pd_q   <= PD_W'(s2.p) + PD_W'(s2.d);
      spin_q <= s2.spin_pos;
      send_q <= s2.send;
    end
    if (adv3o) begin
      drive_voltage <= drive;
      spin_positive <= spin_q;
      send_now      <= send_q;
      sent_voltage  <= send_q ? last_drive : '0;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> drive_voltage != {1'b1, {(DRIVE_W-1){1'b0}}})
    else $error("Drive voltage outside the clamp range.");

  assert property (@(posedge clk) disable iff (rst)
    !s2_ready |-> v3 && out_valid && out_stall)
    else $error("Accumulate stage blocked with room downstream.");

  assert property (@(posedge clk) disable iff (rst)
    adv3o |=> last_drive == drive_voltage)
    else $error("Last drive does not match the delivered voltage.");

endmodule
